/* hdl/tpkf_pkg.sv */
// Package for the target position Kalman filter: widths, codes and saturation helpers.
`timescale 1ns / 1ps
`default_nettype none
package tpkf_pkg;

  localparam int VAR_W  = 48;   // variance width, unsigned Q32.16
  localparam int POS_W  = 32;   // position width, signed Q16.16
  localparam int MA_W   = 98;   // serial multiplier: shifted multiplicand / product
  localparam int MB_W   = 34;   // serial multiplier: multiplier bits, one per cycle
  localparam int MCNT_W = 6;
  localparam int DVD_W  = 80;   // divider dividend bits, one per cycle
  localparam int REM_W  = 50;
  localparam int QUO_W  = 34;
  localparam int DCNT_W = 7;
  localparam int TERM_W = 33;   // distance term, capped at 2^32
  localparam int ISQ_W  = 34;   // root operand width
  localparam int ROOT_W = 17;

  localparam logic [VAR_W-1:0] VAR_MAX  = {VAR_W{1'b1}};
  localparam logic [VAR_W-1:0] VEL_INIT = 48'd100 << 16;
  localparam logic [QUO_W-1:0] TERM_CAP = 34'h1_0000_0000;
  localparam logic [ISQ_W-1:0] ISQ_TOP  = 34'h1_0000_0000;

  // input command codes
  localparam logic [1:0] CMD_PREDICT  = 2'd0;
  localparam logic [1:0] CMD_UPDATE   = 2'd1;
  localparam logic [1:0] CMD_INIT     = 2'd2;

  // configuration register indexes
  localparam logic REG_POS_STD   = 1'b0;
  localparam logic REG_ACCEL_STD = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_PREDICT = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_INIT    = 2'd3
  } lane_op_t;

  typedef struct packed {
    logic     start;
    lane_op_t op;
  } lane_cmd_t;

  // saturate a shifted product to the variance width
  function automatic logic [VAR_W-1:0] sat_var(input logic [MA_W-1:0] v);
    return (|v[MA_W-1:VAR_W]) ? VAR_MAX : v[VAR_W-1:0];
  endfunction

  function automatic logic [VAR_W-1:0] add_sat(input logic [VAR_W-1:0] a,
                                               input logic [VAR_W-1:0] b);
    logic [VAR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAR_W] ? VAR_MAX : s[VAR_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/target_position_kalman_filter.sv */
// Top level of the 2-D target position Kalman filter: ports, command decode, output stage.
// Usage:
//   Input beats on s_axis: tdata carries meas_x, meas_y and time_step, tuser the command
//   (predict, update, force initialise; the fourth code changes nothing). One result beat
//   per input beat on m_axis: est_x, est_y, distance in tdata, ready_res in tuser.
//   Configuration writes (pos_std, accel_std) go over cfg_valid/cfg_index/cfg_data and are
//   always taken; write them only while the filter is idle.
//   One item at a time: s_axis_tready is high only while no item is in work.
//   The per-axis serial multiplier and divider set the time to m_axis_tvalid: predict runs
//   three multiplies; update runs two divides, three multiplies and a 17-step root (only
//   the root when P + R is zero on both axes); init, ignored commands and predict before
//   init go to the output stage directly. The next beat is taken in the cycle after the
//   result is loaded into the output register.
//   The x and y lanes run side by side; the root stage merges their terms.
//   A finished result waits in the output register while the receiver stalls; the next
//   input beat is still accepted and is worked on, its result held until the register frees.
//   Reset (rst, synchronous) clears the filter to not initialised, position and variances
//   zero, pos_std and accel_std 1.0, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module target_position_kalman_filter
  import tpkf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,   // meas_x[31:0], meas_y[63:32], time_step[79:64]
  input  wire logic [1:0]   s_axis_tuser,   // command[1:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [79:0]       m_axis_tdata,   // est_x[31:0], est_y[63:32], distance[79:64]
  output logic [0:0]        m_axis_tuser,   // ready_res[0]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LANE = 4'b0010,
    S_SQRT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t              state;
  logic [15:0]         pos_std, accel_std;
  logic                is_init;
  lane_op_t            op, op_reg;
  lane_cmd_t           lcmd;
  logic                accept;
  logic [31:0]         r2, q;
  logic                busy_x, busy_y, sq_busy, sq_start;
  logic signed [31:0]  pos_x, pos_y;
  logic [TERM_W-1:0]   term_x, term_y;
  logic [ROOT_W-1:0]   root;
  logic [15:0]         distance;
  logic                out_load;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign r2            = 32'(pos_std) * 32'(pos_std);
  assign q             = 32'(accel_std) * 32'(accel_std);
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // command decode
  always_comb begin
    unique case (s_axis_tuser)
      CMD_PREDICT: op = is_init ? OP_PREDICT : OP_NONE;
      CMD_UPDATE:  op = is_init ? OP_UPDATE : OP_INIT;
      CMD_INIT:    op = OP_INIT;
      default:     op = OP_NONE;
    endcase
  end

  assign lcmd.start = accept;
  assign lcmd.op    = op;
  assign sq_start   = (state == S_LANE) && !busy_x && !busy_y && (op_reg == OP_UPDATE);

  tpkf_lane u_lane_x (
    .clk, .rst, .cmd(lcmd), .meas(s_axis_tdata[31:0]), .time_step(s_axis_tdata[79:64]),
    .r2, .q, .busy(busy_x), .pos(pos_x), .term(term_x)
  );

  tpkf_lane u_lane_y (
    .clk, .rst, .cmd(lcmd), .meas(s_axis_tdata[63:32]), .time_step(s_axis_tdata[79:64]),
    .r2, .q, .busy(busy_y), .pos(pos_y), .term(term_y)
  );

  tpkf_isqrt u_isqrt (
    .clk, .rst, .start(sq_start), .v(ISQ_W'(term_x) + ISQ_W'(term_y)),
    .busy(sq_busy), .root
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_std   <= 16'd256;
      accel_std <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POS_STD:   pos_std   <= cfg_data;
        REG_ACCEL_STD: accel_std <= cfg_data;
        default: ;
      endcase
    end
  end

  // item sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      is_init       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      op_reg        <= OP_NONE;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          op_reg <= op;
          if (op == OP_INIT) is_init <= 1'b1;
          state <= S_LANE;
        end
        S_LANE: if (!busy_x && !busy_y) begin
          distance <= '0;
          state    <= (op_reg == OP_UPDATE) ? S_SQRT : S_OUT;
        end
        S_SQRT: if (!sq_busy) begin
          distance <= (|root[ROOT_W-1:16]) ? 16'hFFFF : root[15:0];
          state    <= S_OUT;
        end
        S_OUT: if (out_load) begin
          m_axis_tdata  <= {distance, pos_y, pos_x};
          m_axis_tuser  <= is_init;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/tpkf_lane.sv */
// One axis of the filter: state, serial multiplier and restoring divider under a sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tpkf_lane
  import tpkf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire lane_cmd_t                cmd,
  input  wire logic signed [POS_W-1:0]  meas,
  input  wire logic [15:0]              time_step,
  input  wire logic [31:0]              r2,
  input  wire logic [31:0]              q,
  output logic                          busy,
  output logic signed [POS_W-1:0]       pos,
  output logic [TERM_W-1:0]             term
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_DT2   = 11'b000_0000_0010,
    ST_DT4   = 11'b000_0000_0100,
    ST_T1    = 11'b000_0000_1000,
    ST_T2    = 11'b000_0001_0000,
    ST_T3    = 11'b000_0010_0000,
    ST_K     = 11'b000_0100_0000,
    ST_DELTA = 11'b000_1000_0000,
    ST_NEWP  = 11'b001_0000_0000,
    ST_SQ    = 11'b010_0000_0000,
    ST_TERM  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  logic [VAR_W-1:0]  var_p, var_v, t1, t2;
  logic [15:0]       dt;
  logic [31:0]       dt2;
  logic [63:0]       dt4;
  logic [32:0]       mag, k;
  logic              neg;
  logic [VAR_W:0]    s_reg;

  // serial multiplier
  logic [MA_W-1:0]   m_a, prod, prod_nx;
  logic [MB_W-1:0]   m_b;
  logic [MCNT_W-1:0] mcnt;
  logic              mul_last, mul_load;
  logic [MA_W-1:0]   mul_a_in;
  logic [MB_W-1:0]   mul_b_in;

  // restoring divider, divisor is s_reg
  logic [DVD_W-1:0]  dvd, div_in;
  logic [REM_W-1:0]  rem, r_sh, r_new;
  logic [QUO_W-1:0]  quo, q_sat, q_new;
  logic [DCNT_W-1:0] dcnt;
  logic              div_last, div_load, ge;
  logic [TERM_W-1:0] div_res;

  logic signed [33:0] innov;
  logic [VAR_W:0]     s_comb;
  logic [33:0]        delta;
  logic signed [35:0] np;

  assign busy = (state != ST_IDLE);

  // multiplier step
  assign prod_nx  = m_b[0] ? prod + m_a : prod;
  assign mul_last = (mcnt == MCNT_W'(MB_W - 1));

  // divider step with quotient capping
  assign r_sh     = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign ge       = (r_sh >= {1'b0, s_reg});
  assign r_new    = ge ? r_sh - {1'b0, s_reg} : r_sh;
  assign q_sat    = (quo > TERM_CAP) ? TERM_CAP + QUO_W'(1) : quo;
  assign q_new    = {q_sat[QUO_W-2:0], ge};
  assign div_res  = (q_new > TERM_CAP) ? TERM_CAP[TERM_W-1:0] : q_new[TERM_W-1:0];
  assign div_last = (dcnt == DCNT_W'(DVD_W - 1));

  assign innov  = {{2{meas[POS_W-1]}}, meas} - {{2{pos[POS_W-1]}}, pos};
  assign s_comb = {1'b0, var_p} + {17'd0, r2};
  assign delta  = prod_nx[65:32];
  assign np     = neg ? {{4{pos[POS_W-1]}}, pos} - {2'b0, delta}
                      : {{4{pos[POS_W-1]}}, pos} + {2'b0, delta};

  // sequencer
  always_comb begin
    state_next = state;
    mul_load   = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_load   = 1'b0;
    div_in     = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start && cmd.op == OP_PREDICT) state_next = ST_DT2;
        if (cmd.start && cmd.op == OP_UPDATE && s_comb != '0) begin
          state_next = ST_K;
          div_load   = 1'b1;
          div_in     = {var_p, 32'd0};
        end
      end
      ST_DT2: state_next = ST_DT4;
      ST_DT4: begin
        state_next = ST_T1;
        mul_load   = 1'b1;
        mul_a_in   = MA_W'(var_v);
        mul_b_in   = MB_W'(dt2);
      end
      ST_T1: if (mul_last) begin
        state_next = ST_T2;
        mul_load   = 1'b1;
        mul_a_in   = MA_W'(dt4);
        mul_b_in   = MB_W'(q);
      end
      ST_T2: if (mul_last) begin
        state_next = ST_T3;
        mul_load   = 1'b1;
        mul_a_in   = MA_W'(q);
        mul_b_in   = MB_W'(dt);
      end
      ST_T3: if (mul_last) state_next = ST_IDLE;
      ST_K: if (div_last) begin
        state_next = ST_DELTA;
        mul_load   = 1'b1;
        mul_a_in   = MA_W'(mag);
        mul_b_in   = {1'b0, div_res};
      end
      ST_DELTA: if (mul_last) begin
        state_next = ST_NEWP;
        mul_load   = 1'b1;
        mul_a_in   = MA_W'(var_p);
        mul_b_in   = TERM_CAP - {1'b0, k};
      end
      ST_NEWP: if (mul_last) begin
        state_next = ST_SQ;
        mul_load   = 1'b1;
        mul_a_in   = MA_W'(mag);
        mul_b_in   = {1'b0, mag};
      end
      ST_SQ: if (mul_last) begin
        state_next = ST_TERM;
        div_load   = 1'b1;
        div_in     = prod_nx[DVD_W-1:0];
      end
      ST_TERM: if (div_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      var_p <= '0;
      var_v <= '0;
    end else begin
      state <= state_next;
      // multiplier and divider run every cycle, loads take precedence
      prod <= prod_nx;
      m_a  <= m_a << 1;
      m_b  <= m_b >> 1;
      mcnt <= mcnt + MCNT_W'(1);
      rem  <= r_new;
      quo  <= q_new;
      dvd  <= dvd << 1;
      dcnt <= dcnt + DCNT_W'(1);
      if (mul_load) begin
        prod <= '0;
        m_a  <= mul_a_in;
        m_b  <= mul_b_in;
        mcnt <= '0;
      end
      if (div_load) begin
        rem  <= '0;
        quo  <= '0;
        dvd  <= div_in;
        dcnt <= '0;
      end

      case (state)
        ST_IDLE: if (cmd.start) begin
          dt <= time_step;
          if (cmd.op == OP_INIT) begin
            pos   <= meas;
            var_p <= VAR_W'(r2);
            var_v <= VEL_INIT;
          end
          if (cmd.op == OP_UPDATE) begin
            neg   <= innov[33];
            mag   <= innov[33] ? 33'(-innov) : innov[32:0];
            s_reg <= s_comb;
            // zero innovation variance: no gain, capped term (zero when the innovation is zero)
            if (s_comb == '0) term <= (innov != '0) ? TERM_CAP[TERM_W-1:0] : '0;
          end
        end
        ST_DT2: dt2 <= 32'(dt) * 32'(dt);
        ST_DT4: dt4 <= 64'(dt2) * 64'(dt2);
        ST_T1:  if (mul_last) t1 <= sat_var(prod_nx >> 24);
        ST_T2:  if (mul_last) t2 <= sat_var(prod_nx >> 50);
        ST_T3:  if (mul_last) begin
          var_p <= add_sat(add_sat(var_p, t1), t2);
          var_v <= add_sat(var_v, sat_var(prod_nx >> 12));
        end
        ST_K:   if (div_last) k <= div_res;
        ST_DELTA: if (mul_last) begin
          if (!np[35] && (|np[34:31]))     pos <= 32'sh7FFF_FFFF;
          else if (np[35] && !(&np[34:31])) pos <= 32'sh8000_0000;
          else                              pos <= np[31:0];
        end
        ST_NEWP: if (mul_last) var_p <= prod_nx[79:32];
        ST_TERM: if (div_last) term <= div_res;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/tpkf_isqrt.sv */
// Merging stage: integer square root of the summed axis terms, one result bit per step.
`timescale 1ns / 1ps
`default_nettype none
module tpkf_isqrt
  import tpkf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ISQ_W-1:0]  v,
  output logic                   busy,
  output logic [ROOT_W-1:0]      root
);

  logic [ISQ_W-1:0] rem, res, bitv, trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= v;
      res  <= '0;
      bitv <= ISQ_TOP;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[0]) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* dv/target_position_kalman_filter_test.sv */
// Self-checking testbench for the target position Kalman filter: stimulus, prediction and checks.
`timescale 1ns / 1ps
module target_position_kalman_filter_test;
  import tpkf_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;   // fourth command code, changes nothing
  localparam int IDLE_LIMIT = 4000;            // cycles with no beat before giving up
  localparam int LONG_HOLD  = 600;
  localparam logic [63:0] CAP_Q = 64'h1_0000_0000;

  typedef struct {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic [15:0]        distance;
    logic               ready_res;
  } estimate_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  // filter state as the testbench sees it
  logic signed [31:0] trk_x, trk_y;
  logic [47:0] pvar_x, pvar_y, vvar_x, vvar_y;
  logic tracking;
  logic [15:0] meas_std, proc_std;

  estimate_t pending_est[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit tx_idle_en = 1, rx_idle_en = 1, hold_req = 0;

  target_position_kalman_filter dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // ---------------- arithmetic of the filter ----------------
  function automatic logic [47:0] shift_sat(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] w;
    w = ({64'b0, a} * {64'b0, b}) >> s;
    return (w > {80'b0, VAR_MAX}) ? VAR_MAX : w[47:0];
  endfunction

  function automatic logic [47:0] var_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? VAR_MAX : s[47:0];
  endfunction

  function automatic logic [63:0] quot_cap(input logic [127:0] n, input logic [63:0] d);
    logic [127:0] w;
    w = n / {64'b0, d};
    return (w > {64'b0, CAP_Q}) ? CAP_Q : w[63:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // variance growth over one time step, one axis
  function automatic void grow_variance(inout logic [47:0] p, inout logic [47:0] pv,
                                        input logic [63:0] dt, input logic [63:0] q);
    logic [63:0] dt2;
    dt2 = dt * dt;
    p  = var_add(var_add(p, shift_sat(pv, dt2, 24)), shift_sat(q, dt2 * dt2, 50));
    pv = var_add(pv, shift_sat(q, dt, 12));
  endfunction

  // measurement blend on one axis; returns the distance term
  function automatic logic [63:0] blend_axis(inout logic signed [31:0] pos,
                                             inout logic [47:0] p,
                                             input logic signed [31:0] meas,
                                             input logic [63:0] r2);
    longint innov, np, step;
    logic [63:0] mag, s, k;
    logic [127:0] w;
    innov = longint'(meas) - longint'(pos);
    mag = (innov < 0) ? -innov : innov;
    s = {16'b0, p} + r2;
    k = 0;
    if (s != 0) k = quot_cap({80'b0, p} << 32, s);
    w = {64'b0, mag} * {64'b0, k};
    step = longint'(w[95:32]);
    np = longint'(pos) + ((innov < 0) ? -step : step);
    if (np > 64'sd2147483647) np = 64'sd2147483647;
    if (np < -64'sd2147483648) np = -64'sd2147483648;
    pos = np[31:0];
    p = shift_sat({16'b0, p}, CAP_Q - k, 32);
    if (s == 0) return (mag != 0) ? CAP_Q : 64'd0;
    return quot_cap({64'b0, mag} * {64'b0, mag}, s);
  endfunction

  function automatic void start_track(input logic signed [31:0] mx, input logic signed [31:0] my);
    trk_x = mx;
    trk_y = my;
    pvar_x = 48'(meas_std) * 48'(meas_std);
    pvar_y = pvar_x;
    vvar_x = VEL_INIT;
    vvar_y = VEL_INIT;
    tracking = 1;
  endfunction

  function automatic estimate_t filter_step(input logic [1:0] cmd, input logic signed [31:0] mx,
                                            input logic signed [31:0] my, input logic [15:0] dt);
    estimate_t e;
    logic [63:0] r2, root;
    r2 = 64'(meas_std) * 64'(meas_std);
    e.distance = 0;
    if (cmd == CMD_PREDICT) begin
      if (tracking) begin
        grow_variance(pvar_x, vvar_x, 64'(dt), 64'(proc_std) * 64'(proc_std));
        grow_variance(pvar_y, vvar_y, 64'(dt), 64'(proc_std) * 64'(proc_std));
      end
    end else if (cmd == CMD_INIT || (cmd == CMD_UPDATE && !tracking)) begin
      start_track(mx, my);
    end else if (cmd == CMD_UPDATE) begin
      root = blend_axis(trk_x, pvar_x, mx, r2);
      root = root_floor(root + blend_axis(trk_y, pvar_y, my, r2));
      e.distance = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
    end
    e.est_x = trk_x;
    e.est_y = trk_y;
    e.ready_res = tracking;
    return e;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] mx, input logic [31:0] my,
                           input logic [15:0] dt);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {dt, my, mx};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    pending_est.push_back(filter_step(cmd, mx, my, dt));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_est.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_POS_STD) meas_std = val;
    else proc_std = val;
  endtask

  // mostly tracking sequences around the current estimate, some noise
  task automatic random_items(input int n);
    int r;
    logic [31:0] nx, ny;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      nx = trk_x + $urandom_range(0, 1 << 20) - (1 << 19);
      ny = trk_y + $urandom_range(0, 1 << 20) - (1 << 19);
      if (r < 45) send_item(CMD_UPDATE, nx, ny, 16'($urandom));
      else if (r < 78)
        send_item(CMD_PREDICT, $urandom, $urandom, 16'($urandom_range(0, 8192)));
      else if (r < 84) send_item(CMD_PREDICT, $urandom, $urandom, 16'($urandom));
      else if (r < 91) send_item(CMD_UPDATE, $urandom, $urandom, 16'($urandom));
      else if (r < 96) send_item(CMD_INIT, $urandom, $urandom, 16'($urandom));
      else send_item(CMD_IGNORED, $urandom, $urandom, 16'($urandom));
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_item(CMD_PREDICT, 32'h1234_0000, 32'h5678_0000, 16'd4096);
    send_item(CMD_IGNORED, 32'h0001_0000, 32'h0002_0000, 16'd0);
    send_item(CMD_UPDATE, 32'h03E8_0000, -32'sh03E8_0000, 16'd0);
    send_item(CMD_UPDATE, 32'h03E8_0000, -32'sh03E8_0000, 16'd0);
    send_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_item(CMD_INIT, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
    send_item(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    send_item(CMD_PREDICT, 32'hFFFF_FFFF, 32'h0, 16'd0);
    send_item(CMD_PREDICT, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_PREDICT, 32'h0, 32'h0, 16'hFFFF);
    send_item(CMD_PREDICT, 32'h0, 32'h0, 16'hFFFF);
    send_item(CMD_UPDATE, 32'h0, 32'h0, 16'd0);
    send_item(CMD_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_INIT, 32'h0, 32'h0, 16'd0);
    send_item(CMD_UPDATE, 32'h0001_8000, -32'sh0000_4000, 16'd0);
  endtask

  // zero and extreme standard deviations, including the zero-gain and unit-gain cases
  task automatic test_config_edges();
    write_reg(REG_POS_STD, 16'd0);
    write_reg(REG_ACCEL_STD, 16'd0);
    send_item(CMD_INIT, 32'h0010_0000, 32'h0020_0000, 16'd0);
    send_item(CMD_UPDATE, 32'h0010_0000, 32'h0020_0000, 16'd0);
    send_item(CMD_UPDATE, 32'h0011_0000, 32'h0020_0000, 16'd0);
    send_item(CMD_PREDICT, 32'h0, 32'h0, 16'd4096);
    write_reg(REG_ACCEL_STD, 16'hFFFF);
    send_item(CMD_PREDICT, 32'h0, 32'h0, 16'd4096);
    send_item(CMD_UPDATE, 32'h0050_0000, -32'sh0050_0000, 16'd0);
    write_reg(REG_POS_STD, 16'hFFFF);
    send_item(CMD_INIT, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    send_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
    send_item(CMD_PREDICT, 32'h0, 32'h0, 16'hFFFF);
    write_reg(REG_POS_STD, 16'd1);
    send_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
  endtask

  task automatic test_random_settings();
    logic [15:0] ps[5] = '{16'd256, 16'hFFFF, 16'd1, 16'd0, 16'd128};
    logic [15:0] as[5] = '{16'd256, 16'hFFFF, 16'd0, 16'd16, 16'd1024};
    for (int s = 0; s < 5; s++) begin
      write_reg(REG_POS_STD, (s == 4) ? 16'($urandom) : ps[s]);
      write_reg(REG_ACCEL_STD, (s == 4) ? 16'($urandom_range(0, 4096)) : as[s]);
      random_items(70);
    end
  endtask

  // receiver holds off while items keep coming, then the sender waits for the drain
  task automatic test_back_pressure();
    hold_req = 1;
    random_items(8);
    wait_drained();
    random_items(20);
  endtask

  task automatic test_no_idling();
    wait_drained();
    tx_idle_en = 0;
    rx_idle_en = 0;
    random_items(40);
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    m_axis_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
        hold_req = 0;
        m_axis_tready <= 1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    estimate_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_est.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        e = pending_est.pop_front();
        if (m_axis_tdata[31:0] !== e.est_x || m_axis_tdata[63:32] !== e.est_y ||
            m_axis_tdata[79:64] !== e.distance || m_axis_tuser[0] !== e.ready_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp x=%h y=%h dist=%h rdy=%b, got x=%h y=%h dist=%h rdy=%b",
                     e.est_x, e.est_y, e.distance, e.ready_res, m_axis_tdata[31:0],
                     m_axis_tdata[63:32], m_axis_tdata[79:64], m_axis_tuser[0]);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    rst <= 1;
    s_axis_tvalid <= 0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_valid <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    trk_x = 0;
    trk_y = 0;
    pvar_x = 0;
    pvar_y = 0;
    vvar_x = 0;
    vvar_y = 0;
    tracking = 0;
    meas_std = 16'd256;
    proc_std = 16'd256;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_config_edges();
    test_random_settings();
    test_back_pressure();
    test_no_idling();
    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_est.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tpkf_pkg.sv
hdl/tpkf_lane.sv
hdl/tpkf_isqrt.sv
hdl/target_position_kalman_filter.sv
dv/target_position_kalman_filter_test.sv
